@@ hw/rtl/bcd_rtc_register_file_macros.svh @@
// Assertion macros shared by the clock register file.
// Each check is clocked on the rising edge and switched off during reset.
`ifndef BCD_RTC_REGISTER_FILE_MACROS_SVH
`define BCD_RTC_REGISTER_FILE_MACROS_SVH
`ifndef SYNTH
`define BRTC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("brtc check failed");
`define BRTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("brtc check failed");
`else
`define BRTC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define BRTC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ hw/rtl/brtc_pkg.sv @@
package brtc_pkg;

	// Depth of each RAM page; any value from 13 to 16 is supported.
	localparam int RAM_DEPTH = 13;
	localparam int RAM_AW    = $clog2(RAM_DEPTH);

	localparam logic       CMD_READ  = 1'b0;
	localparam logic       CMD_WRITE = 1'b1;

	localparam logic [3:0] REG_PAGE  = 4'd13;
	localparam logic [3:0] REG_TEST  = 4'd14;
	localparam logic [3:0] REG_RESET = 4'd15;

	// Time page digit registers.
	localparam logic [3:0] TREG_SEC_ONES    = 4'd0;
	localparam logic [3:0] TREG_SEC_TENS    = 4'd1;
	localparam logic [3:0] TREG_MIN_ONES    = 4'd2;
	localparam logic [3:0] TREG_MIN_TENS    = 4'd3;
	localparam logic [3:0] TREG_HOUR_ONES   = 4'd4;
	localparam logic [3:0] TREG_HOUR_TENS   = 4'd5;
	localparam logic [3:0] TREG_WDAY        = 4'd6;
	localparam logic [3:0] TREG_MDAY_ONES   = 4'd7;
	localparam logic [3:0] TREG_MDAY_TENS   = 4'd8;
	localparam logic [3:0] TREG_MONTH_ONES  = 4'd9;
	localparam logic [3:0] TREG_MONTH_TENS  = 4'd10;
	localparam logic [3:0] TREG_YEAR_ONES   = 4'd11;
	localparam logic [3:0] TREG_YEAR_TENS   = 4'd12;

	// Alarm page identity registers.
	localparam logic [3:0] AREG_ONE   = 4'd10;
	localparam logic [3:0] AREG_LEAP  = 4'd11;
	localparam logic [3:0] AREG_ID    = 4'd12;

	localparam logic [1:0] PAGE_TIME  = 2'd0;
	localparam logic [1:0] PAGE_ALARM = 2'd1;
	localparam logic [1:0] PAGE_RAM_A = 2'd2;
	localparam logic [1:0] PAGE_RAM_B = 2'd3;

	localparam logic [7:0] PAD       = 8'hF0;
	localparam logic [7:0] ID_BYTE   = 8'd100;
	localparam logic [7:0] YEAR_LOW  = 8'd90;
	localparam logic [7:0] YEAR_HIGH = 8'd189;

	typedef struct packed {
		logic [7:0] year;
		logic [3:0] month;
		logic [4:0] mday;
		logic [2:0] wday;
		logic [4:0] hour;
		logic [5:0] min;
		logic [5:0] sec;
	} time_t;

	// Quotient by ten for values below 128: multiply by 205 and drop 11 bits.
	function automatic logic [3:0] div10(input logic [6:0] v);
		logic [14:0] prod;
		prod = 15'(v) * 15'd205;
		return prod[14:11];
	endfunction

	// Remainder by ten, from the quotient.
	function automatic logic [3:0] mod10(input logic [6:0] v);
		logic [6:0] tens;
		tens = 7'(div10(v)) * 7'd10;
		return 4'(v - tens);
	endfunction

	// Reset contents of the second RAM page.
	function automatic logic [7:0] ram_b_preset(input int idx);
		case (idx)
			0: return 8'd6;
			1: return 8'd7;
			2: return 8'd1;
			3: return 8'd1;
			default: return 8'd0;
		endcase
	endfunction

endpackage

@@ hw/rtl/brtc_time_digit.sv @@
// Picks one decimal digit of the held time for a time page register.
module brtc_time_digit (
	input  brtc_pkg::time_t held,
	input  logic [3:0]      reg_addr,
	output logic [3:0]      digit
);

	logic [6:0] year_off;

	// The held year is always at least the lower bound once it is valid.
	assign year_off = 7'(held.year - brtc_pkg::YEAR_LOW);

	always_comb begin
		case (reg_addr)
			brtc_pkg::TREG_SEC_ONES:   digit = brtc_pkg::mod10(7'(held.sec));
			brtc_pkg::TREG_SEC_TENS:   digit = brtc_pkg::div10(7'(held.sec));
			brtc_pkg::TREG_MIN_ONES:   digit = brtc_pkg::mod10(7'(held.min));
			brtc_pkg::TREG_MIN_TENS:   digit = brtc_pkg::div10(7'(held.min));
			brtc_pkg::TREG_HOUR_ONES:  digit = brtc_pkg::mod10(7'(held.hour));
			brtc_pkg::TREG_HOUR_TENS:  digit = brtc_pkg::div10(7'(held.hour));
			brtc_pkg::TREG_WDAY:       digit = 4'(held.wday);
			brtc_pkg::TREG_MDAY_ONES:  digit = brtc_pkg::mod10(7'(held.mday));
			brtc_pkg::TREG_MDAY_TENS:  digit = brtc_pkg::div10(7'(held.mday));
			brtc_pkg::TREG_MONTH_ONES: digit = brtc_pkg::mod10(7'(held.month));
			brtc_pkg::TREG_MONTH_TENS: digit = brtc_pkg::div10(7'(held.month));
			brtc_pkg::TREG_YEAR_ONES:  digit = brtc_pkg::mod10(year_off);
			brtc_pkg::TREG_YEAR_TENS:  digit = brtc_pkg::div10(year_off);
			default:                   digit = 4'd0;
		endcase
	end

endmodule

@@ hw/rtl/bcd_rtc_register_file.sv @@
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  tuser: cmd; tdata: address, write byte, time
// m_        out  m_tvalid/m_tready  tdata: read_data
//
// Each request gives exactly one response: the byte read, or zero for a write.
// A request waits in the input register and then moves to the output register,
// which offers its response; with no stall a new request is taken every cycle.
// The output register decouples the sides: the input register moves on when
// the output register is empty or being emptied, and s_tready follows from it.
// Reset (arst_n, asynchronous, active low) clears both valid flags, the page
// state and the time-valid flag, and loads the RAM pages with their presets.
`include "bcd_rtc_register_file_macros.svh"

module bcd_rtc_register_file (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic        s_tuser,   // cmd
	// reg_addr[3:0], write_data[11:4], now_sec[17:12], now_min[23:18],
	// now_hour[28:24], now_wday[31:29], now_mday[36:32], now_month[40:37],
	// now_year[48:41], zero fill [55:49]
	input  logic [55:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata    // read_data
);

	// Input register.
	logic            valid_s1;
	logic            cmd_s1;
	logic [3:0]      addr_s1;
	logic [7:0]      wdata_s1;
	brtc_pkg::time_t now_s1;

	// Clock state.
	logic [1:0]      page_sel_q;
	logic [7:0]      page_byte_q;
	logic            time_valid_q;
	brtc_pkg::time_t held_q;
	logic [7:0]      ram_a_q [brtc_pkg::RAM_DEPTH];
	logic [7:0]      ram_b_q [brtc_pkg::RAM_DEPTH];

	// Output register.
	logic            m_tvalid_q;
	logic [7:0]      m_tdata_q;

	logic            advance;
	logic            s_accept;
	logic            is_write;
	logic            page_wr;
	logic            pad_only_rd;
	logic            s1_stalled;
	logic            ram_hit;
	logic [brtc_pkg::RAM_AW-1:0] ram_idx;
	logic [3:0]      digit;
	logic [7:0]      read_byte;
	logic [7:0]      year_sat;
	brtc_pkg::time_t now_in;
	brtc_pkg::time_t latch_time;

	// The request in the input register completes when the output side can take it.
	assign advance  = valid_s1 && (!m_tvalid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign s_accept = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign now_in.sec   = s_tdata[17:12];
	assign now_in.min   = s_tdata[23:18];
	assign now_in.hour  = s_tdata[28:24];
	assign now_in.wday  = s_tdata[31:29];
	assign now_in.mday  = s_tdata[36:32];
	assign now_in.month = s_tdata[40:37];
	assign now_in.year  = s_tdata[48:41];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			cmd_s1   <= s_tuser;
			addr_s1  <= s_tdata[3:0];
			wdata_s1 <= s_tdata[11:4];
			now_s1   <= now_in;
		end
	end

	// Registers at or above the page register never reach the RAM, even when
	// the RAM is sixteen entries deep.
	assign is_write = advance && (cmd_s1 == brtc_pkg::CMD_WRITE);
	assign page_wr  = is_write && (addr_s1 == brtc_pkg::REG_PAGE);
	assign ram_hit  = (32'(addr_s1) < brtc_pkg::RAM_DEPTH) &&
	                  (addr_s1 != brtc_pkg::REG_PAGE) &&
	                  (addr_s1 != brtc_pkg::REG_TEST) &&
	                  (addr_s1 != brtc_pkg::REG_RESET);
	assign ram_idx  = addr_s1[brtc_pkg::RAM_AW-1:0];

	// The year is saturated into the supported century as it is latched.
	always_comb begin
		if (now_s1.year < brtc_pkg::YEAR_LOW) begin
			year_sat = brtc_pkg::YEAR_LOW;
		end else if (now_s1.year > brtc_pkg::YEAR_HIGH) begin
			year_sat = brtc_pkg::YEAR_HIGH;
		end else begin
			year_sat = now_s1.year;
		end
	end

	always_comb begin
		latch_time      = now_s1;
		latch_time.year = year_sat;
	end

	// A write to the page register selects the page, keeps the byte and
	// latches the time that came with the request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_sel_q   <= brtc_pkg::PAGE_TIME;
			page_byte_q  <= 8'd0;
			time_valid_q <= 1'b0;
			held_q       <= '0;
		end else if (page_wr) begin
			page_sel_q   <= wdata_s1[1:0];
			page_byte_q  <= wdata_s1;
			time_valid_q <= 1'b1;
			held_q       <= latch_time;
		end
	end

	// The two RAM pages are written only while their page is selected.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < brtc_pkg::RAM_DEPTH; i++) begin
				ram_a_q[i] <= 8'd0;
				ram_b_q[i] <= brtc_pkg::ram_b_preset(i);
			end
		end else if (is_write && ram_hit) begin
			if (page_sel_q == brtc_pkg::PAGE_RAM_A) begin
				ram_a_q[ram_idx] <= wdata_s1;
			end else if (page_sel_q == brtc_pkg::PAGE_RAM_B) begin
				ram_b_q[ram_idx] <= wdata_s1;
			end
		end
	end

	brtc_time_digit u_digit (
		.held     (held_q),
		.reg_addr (addr_s1),
		.digit    (digit)
	);

	// Read map. Every byte carries the high-nibble pad except the identity byte.
	always_comb begin
		read_byte = brtc_pkg::PAD;
		if (addr_s1 == brtc_pkg::REG_PAGE) begin
			read_byte = brtc_pkg::PAD | page_byte_q;
		end else if ((addr_s1 != brtc_pkg::REG_TEST) && (addr_s1 != brtc_pkg::REG_RESET)) begin
			case (page_sel_q)
				brtc_pkg::PAGE_TIME: begin
					if (time_valid_q) begin
						read_byte = brtc_pkg::PAD | 8'(digit);
					end
				end
				brtc_pkg::PAGE_ALARM: begin
					if (addr_s1 == brtc_pkg::AREG_ONE) begin
						read_byte = brtc_pkg::PAD | 8'd1;
					end else if (addr_s1 == brtc_pkg::AREG_LEAP) begin
						if (time_valid_q) begin
							read_byte = brtc_pkg::PAD | 8'(held_q.year[1:0]);
						end
					end else if (addr_s1 == brtc_pkg::AREG_ID) begin
						read_byte = brtc_pkg::ID_BYTE;
					end
				end
				brtc_pkg::PAGE_RAM_A: begin
					if (ram_hit) begin
						read_byte = brtc_pkg::PAD | ram_a_q[ram_idx];
					end
				end
				default: begin
					if (ram_hit) begin
						read_byte = brtc_pkg::PAD | ram_b_q[ram_idx];
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_tdata_q <= (cmd_s1 == brtc_pkg::CMD_WRITE) ? 8'd0 : read_byte;
		end
	end

	assign pad_only_rd = advance && (cmd_s1 == brtc_pkg::CMD_READ) && !time_valid_q &&
	                     (page_sel_q == brtc_pkg::PAGE_TIME);
	assign s1_stalled  = valid_s1 && !advance;

	// A write always answers with a zero byte.
	`BRTC_ASSERT_NEXT(a_write_zero, clk, arst_n, is_write, m_tdata_q == 8'd0)
	// A page register write leaves the time marked as latched.
	`BRTC_ASSERT_NEXT(a_page_latch, clk, arst_n, page_wr, time_valid_q)
	// Before any latch, a time page read gives only the pad.
	`BRTC_ASSERT_NEXT(a_time_pad, clk, arst_n, pad_only_rd, m_tdata_q == brtc_pkg::PAD)
	// A stalled request stays in the input register unchanged.
	`BRTC_ASSERT_NEXT(a_s1_hold, clk, arst_n, s1_stalled, valid_s1 && $stable({cmd_s1, addr_s1}))

endmodule

@@ verif/tb_bcd_rtc_register_file.sv @@
`default_nettype none

module tb_bcd_rtc_register_file;
	timeunit 1ns;
	timeprecision 1ps;

	// One register access as it travels on the slave-side stream.
	typedef struct packed {
		logic       cmd;
		logic [3:0] addr;
		logic [7:0] wdata;
		logic [5:0] sec;
		logic [5:0] minute;
		logic [4:0] hour;
		logic [2:0] wday;
		logic [4:0] mday;
		logic [3:0] month;
		logic [7:0] year;
	} access_t;

	// Ready patterns that the receiving side moves between.
	typedef enum logic [1:0] {
		RX_ALWAYS,
		RX_COIN,
		RX_SPARSE,
		RX_MOSTLY
	} rx_mode_e;

	localparam int HOLD_CYCLES = 250;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic        s_tuser  = 1'b0;
	logic [55:0] s_tdata  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;

	bcd_rtc_register_file dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tuser (s_tuser),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	// Requests waiting to be offered, and the read bytes still owed by the block.
	access_t    pending_requests[$];
	logic [7:0] owed_read_bytes[$];

	// The testbench's own copy of the register file state.
	logic [1:0] sel_page;
	logic [7:0] page_reg_byte;
	logic       clock_latched;
	logic [5:0] latched_sec;
	logic [5:0] latched_min;
	logic [4:0] latched_hour;
	logic [2:0] latched_wday;
	logic [4:0] latched_mday;
	logic [3:0] latched_month;
	logic [7:0] latched_year;
	logic [7:0] scratch_a[brtc_pkg::RAM_DEPTH];
	logic [7:0] scratch_b[brtc_pkg::RAM_DEPTH];

	int error_count   = 0;
	int reads_done    = 0;
	int writes_done   = 0;
	int page_switches = 0;
	int responses     = 0;
	int holds_done    = 0;

	initial begin
		forever #10 clk = ~clk;
	end

	// A hung handshake must not keep the run going for ever.
	initial begin
		#4_000_000;
		$display("tb_bcd_rtc_register_file: errors");
		$finish;
	end

	// Bring the state model to its reset contents: nothing latched, page 0, and
	// the second RAM page holding its small preset.
	function automatic void clear_register_model();
		sel_page      = brtc_pkg::PAGE_TIME;
		page_reg_byte = '0;
		clock_latched = 1'b0;
		latched_sec   = '0;
		latched_min   = '0;
		latched_hour  = '0;
		latched_wday  = '0;
		latched_mday  = '0;
		latched_month = '0;
		latched_year  = '0;
		for (int i = 0; i < brtc_pkg::RAM_DEPTH; i++) begin
			scratch_a[i] = '0;
			scratch_b[i] = '0;
		end
		scratch_b[0] = 8'd6;
		scratch_b[1] = 8'd7;
		scratch_b[2] = 8'd1;
		scratch_b[3] = 8'd1;
	endfunction

	// Apply one accepted request to the model and return the byte it should
	// produce. Writes always answer with zero.
	function automatic logic [7:0] apply_access(input access_t a);
		logic [7:0] yr;
		int         year_off;
		logic [7:0] digit;
		if (a.cmd == brtc_pkg::CMD_WRITE) begin
			writes_done++;
			if (a.addr == brtc_pkg::REG_PAGE) begin
				// The page register also takes a snapshot of the clock.
				yr = a.year;
				if (yr < brtc_pkg::YEAR_LOW)
					yr = brtc_pkg::YEAR_LOW;
				if (yr > brtc_pkg::YEAR_HIGH)
					yr = brtc_pkg::YEAR_HIGH;
				sel_page      = a.wdata[1:0];
				page_reg_byte = a.wdata;
				latched_sec   = a.sec;
				latched_min   = a.minute;
				latched_hour  = a.hour;
				latched_wday  = a.wday;
				latched_mday  = a.mday;
				latched_month = a.month;
				latched_year  = yr;
				clock_latched = 1'b1;
				page_switches++;
			end else if (a.addr != brtc_pkg::REG_TEST && a.addr != brtc_pkg::REG_RESET &&
			             int'(a.addr) < brtc_pkg::RAM_DEPTH) begin
				if (sel_page == brtc_pkg::PAGE_RAM_A)
					scratch_a[a.addr] = a.wdata;
				else if (sel_page == brtc_pkg::PAGE_RAM_B)
					scratch_b[a.addr] = a.wdata;
			end
			return 8'h00;
		end

		reads_done++;
		if (a.addr == brtc_pkg::REG_PAGE)
			return brtc_pkg::PAD | page_reg_byte;
		if (a.addr == brtc_pkg::REG_TEST || a.addr == brtc_pkg::REG_RESET)
			return brtc_pkg::PAD;

		case (sel_page)
			brtc_pkg::PAGE_TIME: begin
				if (!clock_latched)
					return brtc_pkg::PAD;
				year_off = int'(latched_year) - int'(brtc_pkg::YEAR_LOW);
				case (a.addr)
					brtc_pkg::TREG_SEC_ONES:   digit = 8'(latched_sec % 10);
					brtc_pkg::TREG_SEC_TENS:   digit = 8'(latched_sec / 10);
					brtc_pkg::TREG_MIN_ONES:   digit = 8'(latched_min % 10);
					brtc_pkg::TREG_MIN_TENS:   digit = 8'(latched_min / 10);
					brtc_pkg::TREG_HOUR_ONES:  digit = 8'(latched_hour % 10);
					brtc_pkg::TREG_HOUR_TENS:  digit = 8'(latched_hour / 10);
					brtc_pkg::TREG_WDAY:       digit = 8'(latched_wday);
					brtc_pkg::TREG_MDAY_ONES:  digit = 8'(latched_mday % 10);
					brtc_pkg::TREG_MDAY_TENS:  digit = 8'(latched_mday / 10);
					brtc_pkg::TREG_MONTH_ONES: digit = 8'(latched_month % 10);
					brtc_pkg::TREG_MONTH_TENS: digit = 8'(latched_month / 10);
					brtc_pkg::TREG_YEAR_ONES:  digit = 8'(year_off % 10);
					brtc_pkg::TREG_YEAR_TENS:  digit = 8'(year_off / 10);
					default:                   digit = 8'h00;
				endcase
				return brtc_pkg::PAD | digit;
			end
			brtc_pkg::PAGE_ALARM: begin
				case (a.addr)
					brtc_pkg::AREG_ONE:  return brtc_pkg::PAD | 8'h01;
					brtc_pkg::AREG_LEAP: return clock_latched ?
					                     (brtc_pkg::PAD | {6'b0, latched_year[1:0]}) :
					                     brtc_pkg::PAD;
					brtc_pkg::AREG_ID:   return brtc_pkg::ID_BYTE;
					default:             return brtc_pkg::PAD;
				endcase
			end
			brtc_pkg::PAGE_RAM_A:
				return (int'(a.addr) < brtc_pkg::RAM_DEPTH) ?
				       (brtc_pkg::PAD | scratch_a[a.addr]) : brtc_pkg::PAD;
			default:
				return (int'(a.addr) < brtc_pkg::RAM_DEPTH) ?
				       (brtc_pkg::PAD | scratch_b[a.addr]) : brtc_pkg::PAD;
		endcase
	endfunction

	// Build a request with the given command, address and byte. The clock
	// fields are mostly plausible, but now and then take any value that their
	// widths allow, so that saturation and odd digit splits are exercised.
	function automatic access_t make_access(input logic cmd, input logic [3:0] addr,
	                                        input logic [7:0] wdata);
		access_t a;
		a.cmd   = cmd;
		a.addr  = addr;
		a.wdata = wdata;
		if ($urandom_range(0, 9) < 8) begin
			a.sec    = 6'($urandom_range(0, 59));
			a.minute = 6'($urandom_range(0, 59));
			a.hour   = 5'($urandom_range(0, 23));
			a.wday   = 3'($urandom_range(0, 6));
			a.mday   = 5'($urandom_range(1, 31));
			a.month  = 4'($urandom_range(1, 12));
			a.year   = 8'($urandom_range(90, 189));
		end else begin
			a.sec    = 6'($urandom);
			a.minute = 6'($urandom);
			a.hour   = 5'($urandom);
			a.wday   = 3'($urandom);
			a.mday   = 5'($urandom);
			a.month  = 4'($urandom);
			a.year   = 8'($urandom);
		end
		return a;
	endfunction

	// A page register write carrying a chosen clock snapshot.
	function automatic access_t page_write(input logic [7:0] data,
	                                       input logic [5:0] sec, input logic [5:0] minute,
	                                       input logic [4:0] hour, input logic [2:0] wday,
	                                       input logic [4:0] mday, input logic [3:0] month,
	                                       input logic [7:0] year);
		access_t a;
		a = make_access(brtc_pkg::CMD_WRITE, brtc_pkg::REG_PAGE, data);
		a.sec    = sec;
		a.minute = minute;
		a.hour   = hour;
		a.wday   = wday;
		a.mday   = mday;
		a.month  = month;
		a.year   = year;
		return a;
	endfunction

	// Sender. Requests leave the queue in bursts of random length, separated by
	// random gaps. A request that is on offer stays there, unchanged, until the
	// block takes it; the prediction is made at the edge where it is taken.
	access_t offered;
	int      burst_left = 1;
	int      gap_left   = 0;
	int      requests_taken = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tuser  <= 1'b0;
			s_tdata  <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				owed_read_bytes.push_back(apply_access(offered));
				requests_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pending_requests.size() > 0) begin
					offered = pending_requests.pop_front();
					s_tvalid <= 1'b1;
					s_tuser  <= offered.cmd;
					s_tdata  <= {7'b0, offered.year, offered.month, offered.mday,
					             offered.wday, offered.hour, offered.minute, offered.sec,
					             offered.wdata, offered.addr};
					if (burst_left <= 1) begin
						// Roughly a third of the bursts run straight on with no gap.
						burst_left = $urandom_range(1, 40);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
					end else begin
						burst_left--;
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver. It moves between a handful of ready patterns, and twice in the
	// run holds off for a long stretch so that the block fills and the sender
	// sees its request stalled.
	rx_mode_e rx_mode      = RX_ALWAYS;
	int       rx_mode_left = 0;
	int       rx_seen      = 0;
	int       hold_left    = 0;
	int       rx_cycle     = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			rx_cycle++;
			if (m_tvalid && m_tready)
				rx_seen++;
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (m_tvalid && m_tready && (rx_seen == 300 || rx_seen == 900)) begin
				hold_left = HOLD_CYCLES;
				holds_done++;
				m_tready <= 1'b0;
			end else begin
				if (rx_mode_left == 0) begin
					rx_mode      = rx_mode_e'($urandom_range(0, 3));
					rx_mode_left = $urandom_range(16, 96);
				end else begin
					rx_mode_left--;
				end
				case (rx_mode)
					RX_ALWAYS: m_tready <= 1'b1;
					RX_COIN:   m_tready <= 1'($urandom);
					RX_SPARSE: m_tready <= (rx_cycle % 4 == 0);
					default:   m_tready <= ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	// Monitor. Every response is matched against the oldest byte still owed.
	logic [7:0] want_byte;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			responses++;
			if (owed_read_bytes.size() == 0) begin
				$error("read_data: response with no request outstanding, actual %02h",
				       m_tdata);
				error_count++;
			end else begin
				want_byte = owed_read_bytes.pop_front();
				if (m_tdata !== want_byte) begin
					$error("read_data mismatch: expected %02h, actual %02h",
					       want_byte, m_tdata);
					error_count++;
				end
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		int      queued;
		int      run_len;
		int      roll;
		int      addr_pick;
		access_t a;

		clear_register_model();

		// Directed part. Reads before any snapshot must give only the pad, and
		// writes to the time page and the test register go nowhere.
		pending_requests.push_back(make_access(brtc_pkg::CMD_READ, brtc_pkg::TREG_SEC_ONES,
		                                       8'($urandom)));
		pending_requests.push_back(make_access(brtc_pkg::CMD_READ, brtc_pkg::TREG_YEAR_ONES,
		                                       8'($urandom)));
		pending_requests.push_back(make_access(brtc_pkg::CMD_READ, brtc_pkg::REG_PAGE,
		                                       8'($urandom)));
		pending_requests.push_back(make_access(brtc_pkg::CMD_READ, brtc_pkg::REG_RESET,
		                                       8'($urandom)));
		pending_requests.push_back(make_access(brtc_pkg::CMD_WRITE, brtc_pkg::TREG_HOUR_TENS,
		                                       8'hFF));
		pending_requests.push_back(make_access(brtc_pkg::CMD_WRITE, brtc_pkg::REG_TEST,
		                                       8'hFF));
		// The clock fields other than the year at the top of their widths; the year of zero saturates up.
		pending_requests.push_back(page_write(8'hFC, 6'd63, 6'd63, 5'd31, 3'd7,
		                                      5'd31, 4'd15, 8'd0));
		pending_requests.push_back(make_access(brtc_pkg::CMD_READ, brtc_pkg::TREG_SEC_ONES,
		                                       8'($urandom)));
		pending_requests.push_back(make_access(brtc_pkg::CMD_READ, brtc_pkg::TREG_SEC_TENS,
		                                       8'($urandom)));
		pending_requests.push_back(make_access(brtc_pkg::CMD_READ, brtc_pkg::TREG_HOUR_ONES,
		                                       8'($urandom)));
		pending_requests.push_back(make_access(brtc_pkg::CMD_READ, brtc_pkg::TREG_HOUR_TENS,
		                                       8'($urandom)));
		pending_requests.push_back(make_access(brtc_pkg::CMD_READ, brtc_pkg::TREG_YEAR_ONES,
		                                       8'($urandom)));
		pending_requests.push_back(make_access(brtc_pkg::CMD_READ, brtc_pkg::TREG_YEAR_TENS,
		                                       8'($urandom)));
		// Alarm page with the year saturating down from the top of its width.
		pending_requests.push_back(page_write(8'h01, 6'd0, 6'd0, 5'd0, 3'd0,
		                                      5'd0, 4'd0, 8'd255));
		pending_requests.push_back(make_access(brtc_pkg::CMD_READ, brtc_pkg::AREG_ONE,
		                                       8'($urandom)));
		pending_requests.push_back(make_access(brtc_pkg::CMD_READ, brtc_pkg::AREG_LEAP,
		                                       8'($urandom)));
		pending_requests.push_back(make_access(brtc_pkg::CMD_READ, brtc_pkg::AREG_ID,
		                                       8'($urandom)));
		// First RAM page: both ends of the address range, written and read back.
		pending_requests.push_back(page_write(8'h06, 6'd0, 6'd0, 5'd0, 3'd0,
		                                      5'd1, 4'd1, 8'd90));
		pending_requests.push_back(make_access(brtc_pkg::CMD_WRITE, brtc_pkg::TREG_YEAR_TENS,
		                                       8'hA5));
		pending_requests.push_back(make_access(brtc_pkg::CMD_WRITE, brtc_pkg::TREG_SEC_ONES,
		                                       8'hFF));
		pending_requests.push_back(make_access(brtc_pkg::CMD_READ, brtc_pkg::TREG_YEAR_TENS,
		                                       8'($urandom)));
		pending_requests.push_back(make_access(brtc_pkg::CMD_READ, brtc_pkg::TREG_SEC_ONES,
		                                       8'($urandom)));
		// Second RAM page still holds its preset.
		pending_requests.push_back(page_write(8'h03, 6'd59, 6'd59, 5'd23, 3'd6,
		                                      5'd31, 4'd12, 8'd189));
		pending_requests.push_back(make_access(brtc_pkg::CMD_READ, brtc_pkg::TREG_SEC_TENS,
		                                       8'($urandom)));
		pending_requests.push_back(make_access(brtc_pkg::CMD_READ, brtc_pkg::REG_PAGE,
		                                       8'($urandom)));
		queued = pending_requests.size();

		// Random part. Most of it is a page selection followed by a run of
		// accesses on that page; the rest is unstructured noise.
		while (queued < 1450) begin
			roll = $urandom_range(0, 9);
			if (roll < 8) begin
				pending_requests.push_back(make_access(brtc_pkg::CMD_WRITE, brtc_pkg::REG_PAGE,
				                                       8'($urandom)));
				queued++;
				run_len = $urandom_range(3, 16);
				for (int i = 0; i < run_len; i++) begin
					addr_pick = ($urandom_range(0, 19) < 17) ? $urandom_range(0, 12)
					                                         : $urandom_range(13, 15);
					a = make_access(($urandom_range(0, 9) < 6) ? brtc_pkg::CMD_READ
					                                           : brtc_pkg::CMD_WRITE,
					                4'(addr_pick), 8'($urandom));
					pending_requests.push_back(a);
					queued++;
				end
			end else begin
				run_len = $urandom_range(1, 6);
				for (int i = 0; i < run_len; i++) begin
					pending_requests.push_back(make_access(1'($urandom), 4'($urandom),
					                                       8'($urandom)));
					queued++;
				end
			end
		end

		// Hold reset, then release it away from the rising edge.
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait until the sender has handed over every request and every response is
		// in, then keep the monitor running on so that anything unexpected is seen.
		while (pending_requests.size() > 0 || s_tvalid)
			@(posedge clk);
		while (owed_read_bytes.size() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Covered %0d requests (%0d reads, %0d writes, %0d page selections).",
		         requests_taken, reads_done, writes_done, page_switches);
		$display("Checked %0d responses through %0d long receiver hold-offs.",
		         responses, holds_done);
		if (error_count == 0)
			$display("tb_bcd_rtc_register_file: clean");
		else
			$display("tb_bcd_rtc_register_file: errors");
		$finish;
	end

endmodule

`default_nettype wire
